/* rtl/core/imu_fifo_record_unpacker_assert.svh */
// assertion macros shared by the imu record unpacker rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef IMU_FIFO_RECORD_UNPACKER_ASSERT_SVH
`define IMU_FIFO_RECORD_UNPACKER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define IMU_ASSERT_IMP(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define IMU_ASSERT_NXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define IMU_ASSERT_IMP(name, clk, rst, pre, post, msg)
`define IMU_ASSERT_NXT(name, clk, rst, pre, post, msg)
`endif
`endif

/* rtl/core/imu_unp_pkg.sv */
// types, constants and helpers for the imu record unpacker
// no dependencies
package imu_unp_pkg;

   localparam logic [15:0] AXIS_MOST_NEG = 16'h8000;
   localparam logic [15:0] AXIS_MOST_POS = 16'h7fff;

   // records that decide the accel phase
   localparam int unsigned LEAD_RECORDS = 4;

   // record position codes
   localparam logic [2:0] POS_FIRST  = 3'd0;
   localparam logic [2:0] POS_DECIDE = 3'(LEAD_RECORDS - 1);
   localparam logic [2:0] POS_EVEN   = 3'd4;
   localparam logic [2:0] POS_ODD    = 3'd5;

   localparam logic KIND_GYRO  = 1'b0;
   localparam logic KIND_ACCEL = 1'b1;

   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic              kind;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic              bad;
      logic              last;
   } imu_unp_rec_type;

   // all results of one record
   typedef struct packed {
      logic [1:0]                         num;
      imu_unp_rec_type [MAX_RESULTS-1:0] slot;
   } imu_unp_set_type;

   function automatic logic [15:0] neg_sat(input logic [15:0] v);
      return (v == AXIS_MOST_NEG) ? AXIS_MOST_POS : 16'(~v + 16'd1);
   endfunction

   function automatic imu_unp_rec_type mk_rec(input logic kind, input logic [15:0] x,
                                              input logic [15:0] y, input logic [15:0] z,
                                              input logic bad);
      imu_unp_rec_type rec;
      rec.kind = kind;
      rec.x    = x;
      rec.y    = neg_sat(y);
      rec.z    = neg_sat(z);
      rec.bad  = bad;
      rec.last = 1'b0;
      return rec;
   endfunction

   // accel triple packed as x | y << 16 | z << 32
   function automatic imu_unp_rec_type mk_accel(input logic [47:0] acc, input logic bad);
      return mk_rec(KIND_ACCEL, acc[15:0], acc[31:16], acc[47:32], bad);
   endfunction

endpackage

/* rtl/core/imu_unp_burst.sv */
// two-deep result set buffer that plays out one record's results a beat at a time
// depends on imu_unp_pkg and imu_fifo_record_unpacker_assert.svh
`include "imu_fifo_record_unpacker_assert.svh"
module imu_unp_burst
   import imu_unp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load_valid,
   input  imu_unp_set_type load_set,
   output logic            load_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output imu_unp_rec_type rsp_rec
);

   logic            a_valid_ff, a_valid_in;
   imu_unp_set_type a_set_ff;
   logic            b_valid_ff, b_valid_in;
   imu_unp_set_type b_set_ff;
   logic [1:0]      b_idx_ff, b_idx_in;
   logic            b_done, b_free, move, load_fire;

   assign b_done     = b_valid_ff && rsp_ready && (b_idx_ff == (b_set_ff.num - 2'd1));
   assign b_free     = !b_valid_ff || b_done;
   assign move       = a_valid_ff && b_free;
   assign load_ready = !a_valid_ff || move;
   assign load_fire  = load_valid && load_ready;

   always_comb begin
      a_valid_in = a_valid_ff;
      if (load_fire) begin
         a_valid_in = 1'b1;
      end else if (move) begin
         a_valid_in = 1'b0;
      end
      b_valid_in = b_valid_ff;
      b_idx_in   = b_idx_ff;
      if (b_free) begin
         b_valid_in = a_valid_ff;
         b_idx_in   = 2'd0;
      end else if (b_valid_ff && rsp_ready) begin
         b_idx_in = b_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         b_idx_ff   <= 2'd0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         b_idx_ff   <= b_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         a_set_ff <= load_set;
      end
      if (move) begin
         b_set_ff <= a_set_ff;
      end
   end

   assign rsp_valid = b_valid_ff;
   assign rsp_rec   = b_set_ff.slot[b_idx_ff];

   `IMU_ASSERT_IMP(a_idx_in_set, clock, reset, b_valid_ff, b_idx_ff < b_set_ff.num, "result index past set count")
   `IMU_ASSERT_IMP(a_set_nonempty, clock, reset, b_valid_ff, b_set_ff.num != 2'd0, "empty result set in play")
   `IMU_ASSERT_NXT(a_hold_pending, clock, reset, a_valid_ff && !b_free, a_valid_ff, "pending set dropped")
   `IMU_ASSERT_NXT(a_drain_empty, clock, reset, b_done && !a_valid_ff, !b_valid_ff, "buffer refilled from nothing")

endmodule

/* rtl/core/imu_fifo_record_unpacker.sv */
// top level of the imu fifo record unpacker: record decode, phase tracking, accel hold
// depends on imu_unp_pkg, imu_unp_burst and imu_fifo_record_unpacker_assert.svh
//
// usage
//  - req channel: one beat per fifo record (accel and gyro axes, last_of_batch on the
//    final record of a batch)
//  - rsp channel: one beat per result; each record gives a gyro beat, then zero to two
//    accel beats; last_result marks the final beat caused by the batch's last record
//  - accel phase is decided on the fourth record of a batch from the accel triples of
//    the first four records; phase_bad reports an unrecognized duplication pattern
//  - throughput: one req beat per cycle while each record makes one result and rsp_ready
//    stays high; a record that makes n results holds the result side until all n are taken,
//    so sustained rate is set by the result count (one beat per cycle on rsp while rsp_ready is high)
//  - the record is decoded in the accept cycle into a result set register; a second set
//    register feeds rsp, so a new record is taken while results still wait on rsp
//  - rsp stall: req_ready drops once both set registers are full, no beat is lost
//  - reset: synchronous, clears position, phase and bad flag and empties the buffer;
//    the accel hold needs no clear since every batch writes it before reading
`include "imu_fifo_record_unpacker_assert.svh"
module imu_fifo_record_unpacker
   import imu_unp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic               req_last_of_batch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic               rsp_phase_bad,
   output logic               rsp_last_result
);

   // batch state
   logic [47:0]     accel_hold_ff [3];
   logic [2:0]      record_position_ff, record_position_in;
   logic            odd_phase_ff, odd_phase_in;
   logic            batch_bad_ff, batch_bad_in;

   logic            req_fire;
   logic [47:0]     acc_cur;
   logic            lead, decide;
   logic            e01, e23, e12;
   logic            odd_now, bad_now;
   imu_unp_set_type set_cur;
   imu_unp_rec_type rsp_rec;

   assign req_fire = req_valid && req_ready;
   assign acc_cur  = {req_accel_z, req_accel_y, req_accel_x};
   assign lead     = record_position_ff < POS_DECIDE;
   assign decide   = record_position_ff == POS_DECIDE;

   // duplication pattern over the first four accel triples
   assign e01 = accel_hold_ff[0] == accel_hold_ff[1];
   assign e23 = accel_hold_ff[2] == acc_cur;
   assign e12 = accel_hold_ff[1] == accel_hold_ff[2];

   always_comb begin
      odd_now = odd_phase_ff;
      bad_now = batch_bad_ff;
      if (decide) begin
         if (e01 && e23) begin
            odd_now = 1'b1;
         end else if (e12) begin
            odd_now = 1'b0;
         end else begin
            odd_now = 1'b1;
            bad_now = 1'b1;
         end
      end
   end

   // result set of the current record
   always_comb begin
      set_cur.num     = 2'd1;
      set_cur.slot[0] = mk_rec(KIND_GYRO, req_gyro_x, req_gyro_y, req_gyro_z, bad_now);
      set_cur.slot[1] = mk_accel(acc_cur, bad_now);
      set_cur.slot[2] = mk_accel(acc_cur, bad_now);
      if (lead) begin
         // short batch: odd phase, record 1 accel (just arriving when at position 1)
         if (req_last_of_batch && (record_position_ff != POS_FIRST)) begin
            set_cur.num = 2'd2;
            if (record_position_ff != 3'd1) begin
               set_cur.slot[1] = mk_accel(accel_hold_ff[1], bad_now);
            end
         end
      end else if (decide) begin
         set_cur.num = 2'd3;
         if (odd_now) begin
            set_cur.slot[1] = mk_accel(accel_hold_ff[1], bad_now);
         end else begin
            set_cur.slot[1] = mk_accel(accel_hold_ff[0], bad_now);
            set_cur.slot[2] = mk_accel(accel_hold_ff[2], bad_now);
         end
      end else if (record_position_ff[0] == odd_phase_ff) begin
         set_cur.num = 2'd2;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         set_cur.slot[i].last = req_last_of_batch && (2'(i) == (set_cur.num - 2'd1));
      end
   end

   // next batch state
   always_comb begin
      record_position_in = record_position_ff;
      odd_phase_in       = odd_phase_ff;
      batch_bad_in       = batch_bad_ff;
      if (lead) begin
         record_position_in = record_position_ff + 3'd1;
      end else if (decide) begin
         record_position_in = POS_EVEN;
         odd_phase_in       = odd_now;
         batch_bad_in       = bad_now;
      end else begin
         record_position_in = record_position_ff[0] ? POS_EVEN : POS_ODD;
      end
      if (req_last_of_batch) begin
         record_position_in = POS_FIRST;
         odd_phase_in       = 1'b1;
         batch_bad_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_position_ff <= POS_FIRST;
         odd_phase_ff       <= 1'b1;
         batch_bad_ff       <= 1'b0;
      end else if (req_fire) begin
         record_position_ff <= record_position_in;
         odd_phase_ff       <= odd_phase_in;
         batch_bad_ff       <= batch_bad_in;
      end
   end

   // accel of the first three records
   always_ff @(posedge clock) begin
      if (req_fire && lead) begin
         accel_hold_ff[record_position_ff[1:0]] <= acc_cur;
      end
   end

   imu_unp_burst u_burst (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid),
      .load_set   (set_cur),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_rec    (rsp_rec)
   );

   assign rsp_kind        = rsp_rec.kind;
   assign rsp_out_x       = rsp_rec.x;
   assign rsp_out_y       = rsp_rec.y;
   assign rsp_out_z       = rsp_rec.z;
   assign rsp_phase_bad   = rsp_rec.bad;
   assign rsp_last_result = rsp_rec.last;

   `IMU_ASSERT_IMP(a_pos_range, clock, reset, 1'b1, record_position_ff <= POS_ODD, "record position out of range")
   `IMU_ASSERT_NXT(a_batch_end, clock, reset, req_fire && req_last_of_batch, (record_position_ff == POS_FIRST) && odd_phase_ff && !batch_bad_ff, "batch state not restored")
   `IMU_ASSERT_NXT(a_past_lead, clock, reset, req_fire && !req_last_of_batch && !lead, (record_position_ff == POS_EVEN) || (record_position_ff == POS_ODD), "left steady position")
   `IMU_ASSERT_IMP(a_bad_odd, clock, reset, batch_bad_ff, odd_phase_ff, "bad batch not on odd phase")

endmodule

/* bench/imu_fifo_record_unpacker_tb.sv */
// self-checking bench for imu_fifo_record_unpacker: directed batches, back-pressure, random batches
// depends on imu_unp_pkg and the unpacker rtl; predicts every result beat and checks it in order
module imu_fifo_record_unpacker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import imu_unp_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_RECORDS = 150;
   localparam int DRAIN_CYCLES   = 16;
   localparam int MAX_WAIT       = 13;

   // accel triples packed as z | y | x, picked so every axis meets an extreme
   localparam logic [47:0] ACC_P     = {16'h0000, AXIS_MOST_POS, AXIS_MOST_NEG};
   localparam logic [47:0] ACC_Q     = {16'h0001, AXIS_MOST_NEG, 16'hffff};
   localparam logic [47:0] ACC_R     = {AXIS_MOST_NEG, 16'hfedc, 16'h1234};
   localparam logic [47:0] ACC_S     = {16'hffff, 16'h0000, AXIS_MOST_POS};
   localparam logic [47:0] GYRO_EDGE = {AXIS_MOST_POS, AXIS_MOST_NEG, AXIS_MOST_NEG};

   // how accel samples repeat across the records of a random batch
   typedef enum {DUP_ODD, DUP_EVEN, DUP_BROKEN, NOISE} batch_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_accel_x = '0;
   logic signed [15:0] req_accel_y = '0;
   logic signed [15:0] req_accel_z = '0;
   logic signed [15:0] req_gyro_x = '0;
   logic signed [15:0] req_gyro_y = '0;
   logic signed [15:0] req_gyro_z = '0;
   logic               req_last_of_batch = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_kind;
   logic signed [15:0] rsp_out_x;
   logic signed [15:0] rsp_out_y;
   logic signed [15:0] rsp_out_z;
   logic               rsp_phase_bad;
   logic               rsp_last_result;

   // expected result beats, oldest first
   imu_unp_rec_type expected_beats [$];
   int              mismatches = 0;
   int              cycle_count = 0;

   // pacing controls: steady means no idle cycles on that side
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   int rsp_hold_cycles = 0;

   // predictor state: accel of records 0..2, position in batch, phase and bad flag
   logic [47:0] held_accel [3] = '{default: '0};
   logic [2:0]  rec_pos = POS_FIRST;
   logic        odd_sel = 1'b1;
   logic        batch_bad = 1'b0;

   imu_fifo_record_unpacker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_accel_z       (req_accel_z),
      .req_gyro_x        (req_gyro_x),
      .req_gyro_y        (req_gyro_y),
      .req_gyro_z        (req_gyro_z),
      .req_last_of_batch (req_last_of_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_phase_bad     (rsp_phase_bad),
      .rsp_last_result   (rsp_last_result)
   );

   always #4 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int draw_wait(input bit steady);
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // one axis value, biased toward the extremes of the range
   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 7))
         0: return AXIS_MOST_NEG;
         1: return AXIS_MOST_POS;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_triple();
      return {rand_axis(), rand_axis(), rand_axis()};
   endfunction

   // y and z are mirrored; the most negative value has no negation and clips
   function automatic logic [15:0] flip_axis(input logic [15:0] v);
      if (v == AXIS_MOST_NEG)
         return AXIS_MOST_POS;
      return 16'(16'h0000 - v);
   endfunction

   function automatic imu_unp_rec_type expect_beat(input logic kind, input logic [47:0] trio,
                                                   input logic bad);
      imu_unp_rec_type beat;
      beat.kind = kind;
      beat.x    = trio[15:0];
      beat.y    = flip_axis(trio[31:16]);
      beat.z    = flip_axis(trio[47:32]);
      beat.bad  = bad;
      beat.last = 1'b0;
      return beat;
   endfunction

   // works out the beats one accepted record causes and queues them
   task automatic predict_record(input logic [47:0] accel, input logic [47:0] gyro,
                                 input logic last);
      imu_unp_rec_type burst [$];
      imu_unp_rec_type beat;
      logic [2:0]      pos;
      pos = rec_pos;
      // fourth record: duplication pattern of the first four decides the phase
      if (pos == POS_DECIDE) begin
         if (held_accel[0] == held_accel[1] && held_accel[2] == accel) begin
            odd_sel = 1'b1;
         end else if (held_accel[1] == held_accel[2]) begin
            odd_sel = 1'b0;
         end else begin
            odd_sel   = 1'b1;
            batch_bad = 1'b1;
         end
      end
      burst.push_back(expect_beat(KIND_GYRO, gyro, batch_bad));
      if (pos < POS_DECIDE) begin
         held_accel[pos] = accel;
         // short batch: odd phase by default, so record 1 is the only accel
         if (last && pos != POS_FIRST)
            burst.push_back(expect_beat(KIND_ACCEL, held_accel[1], batch_bad));
         rec_pos = pos + 3'd1;
      end else if (pos == POS_DECIDE) begin
         if (odd_sel) begin
            burst.push_back(expect_beat(KIND_ACCEL, held_accel[1], batch_bad));
            burst.push_back(expect_beat(KIND_ACCEL, accel, batch_bad));
         end else begin
            burst.push_back(expect_beat(KIND_ACCEL, held_accel[0], batch_bad));
            burst.push_back(expect_beat(KIND_ACCEL, held_accel[2], batch_bad));
         end
         rec_pos = POS_EVEN;
      end else begin
         // past the first four: low bit of the position is the record index parity
         if (pos[0] == odd_sel)
            burst.push_back(expect_beat(KIND_ACCEL, accel, batch_bad));
         rec_pos = pos[0] ? POS_EVEN : POS_ODD;
      end
      foreach (burst[i]) begin
         beat      = burst[i];
         beat.last = last && (i == burst.size() - 1);
         expected_beats.push_back(beat);
      end
      if (last) begin
         rec_pos   = POS_FIRST;
         odd_sel   = 1'b1;
         batch_bad = 1'b0;
      end
   endtask

   // offers one record after a random gap and waits for its beat
   task automatic send_record(input logic [47:0] accel, input logic [47:0] gyro,
                              input logic last);
      int gap;
      gap = draw_wait(req_steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_accel_x       <= accel[15:0];
      req_accel_y       <= accel[31:16];
      req_accel_z       <= accel[47:32];
      req_gyro_x        <= gyro[15:0];
      req_gyro_y        <= gyro[31:16];
      req_gyro_z        <= gyro[47:32];
      req_last_of_batch <= last;
      do @(posedge clock); while (!req_ready);
      predict_record(accel, gyro, last);
   endtask

   // random batch; duplicated styles pair records the way the sensor fifo does
   task automatic run_batch(input int len, input batch_style_type style);
      logic [47:0] samples [$];
      logic [47:0] accel;
      int          shift;
      int          spoil;
      int          pick;
      for (int k = 0; k <= len; k++)
         samples.push_back(rand_triple());
      shift = (style == DUP_EVEN) ? 1 : (style == DUP_BROKEN) ? $urandom_range(0, 1) : 0;
      spoil = (style == DUP_BROKEN) ? $urandom_range(0, 3) : -1;
      for (int i = 0; i < len; i++) begin
         pick  = (style == NOISE) ? i : (i + shift) / 2;
         accel = (i == spoil) ? rand_triple() : samples[pick];
         send_record(accel, rand_triple(), i == len - 1);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result side pacing: random stall per beat, or one long hold when asked
   initial begin : rsp_pacing
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = draw_wait(rsp_steady);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // every accepted beat against the oldest expectation
   always @(posedge clock) begin : rsp_check
      imu_unp_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: beat with nothing expected, actual kind %0d x %h y %h z %h",
                     $time, rsp_kind, rsp_out_x, rsp_out_y, rsp_out_z);
            mismatches++;
         end else begin
            want = expected_beats.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("out_x", want.x, rsp_out_x);
            check_field("out_y", want.y, rsp_out_y);
            check_field("out_z", want.z, rsp_out_z);
            check_field("phase_bad", want.bad, rsp_phase_bad);
            check_field("last_result", want.last, rsp_last_result);
         end
      end
   end

   // one, two and three record batches end before the phase decision
   task automatic test_short_batches();
      send_record(ACC_P, GYRO_EDGE, 1'b1);
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_Q, GYRO_EDGE, 1'b1);
      send_record(ACC_Q, rand_triple(), 1'b0);
      send_record(ACC_R, rand_triple(), 1'b0);
      send_record(ACC_S, rand_triple(), 1'b1);
   endtask

   // pairs start at record 0
   task automatic test_odd_phase();
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_Q, GYRO_EDGE, 1'b0);
      send_record(ACC_Q, rand_triple(), 1'b0);
      send_record(ACC_R, rand_triple(), 1'b1);
   endtask

   // r0 == r1 == r2 but r2 != r3: falls through to the even phase
   task automatic test_even_phase();
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_Q, rand_triple(), 1'b0);
      send_record(ACC_Q, GYRO_EDGE, 1'b1);
   endtask

   // all four equal matches both patterns, odd wins
   task automatic test_all_equal();
      repeat (3) send_record(ACC_R, rand_triple(), 1'b0);
      send_record(ACC_R, rand_triple(), 1'b1);
   endtask

   // no duplication at all: flagged bad, odd indices
   task automatic test_bad_pattern();
      send_record(ACC_P, rand_triple(), 1'b0);
      send_record(ACC_Q, rand_triple(), 1'b0);
      send_record(ACC_R, rand_triple(), 1'b0);
      send_record(ACC_S, GYRO_EDGE, 1'b1);
   endtask

   // receiver holds off while records keep coming, so req_ready must drop
   task automatic test_result_stall();
      req_steady      = 1'b1;
      rsp_steady      = 1'b1;
      rsp_hold_cycles = 120;
      run_batch(12, DUP_ODD);
   endtask

   task automatic test_random_batches();
      int              sent;
      int              len;
      int              roll;
      batch_style_type style;
      sent = 0;
      while (sent < RANDOM_RECORDS) begin
         req_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         roll  = $urandom_range(0, 19);
         style = (roll < 8) ? DUP_ODD : (roll < 15) ? DUP_EVEN :
                 (roll < 17) ? NOISE : DUP_BROKEN;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
         run_batch(len, style);
         sent += len;
      end
   endtask

   initial begin : regression
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_short_batches();
      test_odd_phase();
      test_even_phase();
      test_all_equal();
      test_bad_pattern();
      test_result_stall();
      test_random_batches();
      req_valid <= 1'b0;
      // drain, then a few quiet cycles to catch stray beats
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/imu_unp_pkg.sv
rtl/core/imu_unp_burst.sv
rtl/core/imu_fifo_record_unpacker.sv
bench/imu_fifo_record_unpacker_tb.sv
